// ===== hdl/lsmf_pkg.sv =====
// Shared types and constants of the level sensor mode filter.
`timescale 1ns / 1ps

package lsmf_pkg;

  localparam int DATA_W     = 32;  // scaled values, thresholds, averages
  localparam int RAW_W      = 16;  // raw capture count
  localparam int SPS_W      = 16;  // samples-per-second multiplier
  localparam int CFG_ADDR_W = 3;
  localparam int OUT_TDATA_W = 40; // 34 payload bits padded to whole bytes

  localparam int WINDOW_DEF    = 6;
  localparam int ERROR_RUN_DEF = 10;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ENABLE          = 3'd0,
    REG_SAMPLES_PER_SEC = 3'd1,
    REG_UPPER_THRESHOLD = 3'd2,
    REG_LOWER_THRESHOLD = 3'd3,
    REG_INITIAL_VALUE   = 3'd4
  } cfg_reg_t;

endpackage

// ===== hdl/lsmf_cell.sv =====
// One window cell: holds one stored average, shifts it on, compares it.
`timescale 1ns / 1ps

module lsmf_cell (
  input  logic                       clk,
  input  logic                       shift,  // take din this cycle
  input  logic [lsmf_pkg::DATA_W-1:0] din,   // from the left neighbor
  input  logic [lsmf_pkg::DATA_W-1:0] cmp,   // broadcast scan candidate
  output logic [lsmf_pkg::DATA_W-1:0] q,     // to the right neighbor
  output logic                       match
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= din;
    end
  end

  assign match = (q == cmp);

endmodule

// ===== hdl/level_sensor_mode_filter.sv =====
// Top level of the level sensor mode filter: sequencer, averaging and window chain.
// Steps: disabled words pass S_IDLE, S_DONE; enabled words S_IDLE, S_MUL, S_UPD, S_DONE,
//   plus S_SCAN and S_MODE before S_DONE when an in-range word finds the window full.
// A new word is taken only in S_IDLE, after the last has left S_DONE, which waits for a
//   free output register. The mode scan walks the cell chain one entry per cycle.
// Reset (rst, synchronous): clears control state, the average, the window fill, the
//   error run and flag, the reported value and the registers to their defaults.
`timescale 1ns / 1ps

module level_sensor_mode_filter #(
  parameter int WINDOW    = lsmf_pkg::WINDOW_DEF,
  parameter int ERROR_RUN = lsmf_pkg::ERROR_RUN_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [lsmf_pkg::RAW_W-1:0]       s_tdata,  // [15:0] raw_count
  // output stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [lsmf_pkg::OUT_TDATA_W-1:0] m_tdata,  // [31:0] level_value,
                                                     // [32] sensor_error,
                                                     // [33] value_updated, rest 0
  // configuration writes
  input  logic                            cfg_we,
  input  logic [lsmf_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [lsmf_pkg::DATA_W-1:0]      cfg_data
);

  localparam int DW     = lsmf_pkg::DATA_W;
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int IDX_W  = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int RUN_W  = $clog2(ERROR_RUN + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,  // wait for a word
    S_MUL  = 6'b000010,  // scale the raw count
    S_UPD  = 6'b000100,  // range check, average, window insert
    S_SCAN = 6'b001000,  // walk the chain counting matches
    S_MODE = 6'b010000,  // load the mode as the reported value
    S_DONE = 6'b100000   // hand the result to the output register
  } state_t;

  state_t state;

  // configuration registers; initial_value only loads the reported value
  logic                       enable;
  logic [lsmf_pkg::SPS_W-1:0] samples_per_sec;
  logic [DW-1:0]              upper_threshold;
  logic [DW-1:0]              lower_threshold;

  // filter state
  logic [lsmf_pkg::RAW_W-1:0] raw;
  logic [DW-1:0]              scaled;
  logic [DW-1:0]              running_average;
  logic                       average_started;
  logic [FILL_W-1:0]          window_fill;
  logic [RUN_W-1:0]           bad_run;
  logic                       error_sticky;
  logic [DW-1:0]              reported_value;
  logic                       updated;

  // mode scan
  logic [IDX_W-1:0]           scan_idx;
  logic [CNT_W-1:0]           best_count;
  logic [DW-1:0]              best;

  // cell chain
  logic [DW-1:0]              cell_q   [WINDOW];
  logic [WINDOW-1:0]          cell_match;
  logic [DW-1:0]              chain_in;
  logic                       chain_shift;
  logic [DW-1:0]              head;
  logic [CNT_W-1:0]           match_count;

  logic                       in_range;
  logic [DW:0]                avg_sum;
  logic [DW-1:0]              average_next;
  logic                       window_full;
  logic                       out_free;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // The oldest entry sits at the far end of the chain; during the scan the chain
  // rotates so the entries come past the head in order of arrival.
  assign head        = cell_q[WINDOW-1];
  assign window_full = (window_fill == FILL_W'(WINDOW));

  assign in_range = (scaled >= lower_threshold) && (scaled <= upper_threshold);
  assign avg_sum  = {1'b0, running_average} + {1'b0, scaled};
  assign average_next = average_started ? avg_sum[DW:1] : scaled;

  assign chain_shift = ((state == S_UPD) && in_range && !window_full) ||
                       (state == S_SCAN);
  assign chain_in    = (state == S_SCAN) ? head : average_next;

  genvar gi;
  generate
    for (gi = 0; gi < WINDOW; gi++) begin : g_cell
      lsmf_cell u_cell (
        .clk   (clk),
        .shift (chain_shift),
        .din   ((gi == 0) ? chain_in : cell_q[(gi == 0) ? 0 : gi - 1]),
        .cmp   (head),
        .q     (cell_q[gi]),
        .match (cell_match[gi])
      );
    end
  endgenerate

  // Count how many cells hold the head value.
  always_comb begin
    match_count = '0;
    for (int k = 0; k < WINDOW; k++) begin
      match_count = match_count + CNT_W'(cell_match[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      enable          <= 1'b0;
      samples_per_sec <= lsmf_pkg::SPS_W'(1);
      upper_threshold <= '1;
      lower_threshold <= '0;
      running_average <= '0;
      average_started <= 1'b0;
      window_fill     <= '0;
      bad_run         <= '0;
      error_sticky    <= 1'b0;
      reported_value  <= '0;
      updated         <= 1'b0;
      scan_idx        <= '0;
      best_count      <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            raw     <= s_tdata;
            updated <= 1'b0;
            // Disabled: go straight to the report; only raw and the update flag change.
            state   <= enable ? S_MUL : S_DONE;
          end
        end
        S_MUL: begin
          // 16 x 16 bits always fits in 32, so the product never saturates.
          scaled <= DW'(raw) * DW'(samples_per_sec);
          state  <= S_UPD;
        end
        S_UPD: begin
          if (in_range) begin
            bad_run         <= '0;
            running_average <= average_next;
            average_started <= 1'b1;
            if (!window_full) begin
              window_fill <= window_fill + FILL_W'(1);
              state       <= S_DONE;
            end else begin
              window_fill <= '0;
              scan_idx    <= '0;
              best_count  <= '0;
              state       <= S_SCAN;
            end
          end else begin
            if (bad_run == RUN_W'(ERROR_RUN - 1)) begin
              bad_run      <= '0;
              error_sticky <= 1'b1;
            end else begin
              bad_run <= bad_run + RUN_W'(1);
            end
            state <= S_DONE;
          end
        end
        S_SCAN: begin
          // Strictly greater keeps the earliest entry on a tie.
          if (match_count > best_count) begin
            best_count <= match_count;
            best       <= head;
          end
          scan_idx <= scan_idx + IDX_W'(1);
          if (scan_idx == IDX_W'(WINDOW - 1)) begin
            state <= S_MODE;
          end
        end
        S_MODE: begin
          reported_value <= best;
          updated        <= 1'b1;
          state          <= S_DONE;
        end
        S_DONE: begin
          // Hold here until the output register is free.
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {(lsmf_pkg::OUT_TDATA_W - DW - 2)'(0), updated, error_sticky,
                         reported_value};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // Writes must arrive only while the block is idle; the block does not enforce this.
      if (cfg_we) begin
        case (cfg_addr)
          lsmf_pkg::REG_ENABLE:          enable          <= cfg_data[0];
          lsmf_pkg::REG_SAMPLES_PER_SEC: samples_per_sec <= cfg_data[lsmf_pkg::SPS_W-1:0];
          lsmf_pkg::REG_UPPER_THRESHOLD: upper_threshold <= cfg_data;
          lsmf_pkg::REG_LOWER_THRESHOLD: lower_threshold <= cfg_data;
          lsmf_pkg::REG_INITIAL_VALUE: begin
            reported_value <= cfg_data;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // The window never holds more than WINDOW entries.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    window_fill <= FILL_W'(WINDOW))
    else $error("window fill above window size");

  // The error run counter wraps before reaching the error run length.
  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    bad_run < RUN_W'(ERROR_RUN))
    else $error("error run counter out of range");

  // Only reset clears the error flag.
  a_sticky: assert property (@(posedge clk) disable iff (rst)
    !$fell(error_sticky))
    else $error("sensor error flag cleared without reset");

  // A mode result always follows a scan, and the window is empty by then.
  a_mode_after_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_MODE) |-> ($past(state) == S_SCAN) && (window_fill == '0))
    else $error("mode loaded without a full scan");

endmodule
